>>> rtl/ipral_pkg.sv
package ipral_pkg;

  localparam int MAX_RANGES_DEF = 64;
  localparam int ADDR_W = 128;
  localparam int IPV4_OFFSET = 128 - 32;
  localparam int FULL_LEN = 128;

  localparam logic [2:0] FUNC_BEGIN  = 3'd0;
  localparam logic [2:0] FUNC_ADD    = 3'd1;
  localparam logic [2:0] FUNC_COMMIT = 3'd2;
  localparam logic [2:0] FUNC_QUERY  = 3'd3;
  localparam logic [2:0] FUNC_ALL    = 3'd4;
  localparam logic [2:0] FUNC_NONE   = 3'd5;

  localparam logic [1:0] KIND_SINGLE = 2'd0;
  localparam logic [1:0] KIND_PREFIX = 2'd1;
  localparam logic [1:0] KIND_RANGE  = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD     = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_REFUSED = 2'd3;

  typedef logic [ADDR_W-1:0] addr_t;

  typedef struct packed {
    addr_t lo_bound;
    addr_t hi_bound;
  } range_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_Q_SCAN,
    S_RK_ITEM,
    S_RK_FIRST,
    S_RK_SCAN,
    S_RK_WR,
    S_MG_RD,
    S_MG_SCAN,
    S_MG_FIN,
    S_RESP
  } state_t;

endpackage

>>> rtl/ipral_ram.sv
module ipral_ram import ipral_pkg::*; #(
  parameter int WIDTH = 256,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/ip_range_allow_list.sv
// Range allow list over 128-bit addresses. Every input item yields exactly one
// result item. Begin, add, match-all, match-none and unused codes go straight to
// the response. A query scans the active table one entry a cycle through the
// active memory's read port and stops at the first hit or the last entry. A
// commit ranks every staged item against all staged items through the staging
// memory port, then merges them in one pass over the active memory. Only one
// item is worked on at a time; a finished result waits in the output register.
module ip_range_allow_list import ipral_pkg::*; #(
  parameter int MAX_RANGES = MAX_RANGES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // first_addr_hi, first_addr_lo, last_addr_hi, last_addr_lo, prefix_len, ipv4_prefix
  input  logic [271:0] s_tdata,
  // func, item_kind
  input  logic [4:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // is_listed, status, range_count, match_all, match_none
  output logic [15:0]  m_tdata
);

  localparam int IW = $clog2(MAX_RANGES);
  localparam int CW = $clog2(MAX_RANGES + 1);
  localparam int RW = 2 * ADDR_W;

  state_t state, state_next;

  logic [2:0]   in_func;
  logic [1:0]   in_kind;
  addr_t        in_first, in_last;
  logic [7:0]   in_plen;
  logic         in_v4;

  assign in_func  = s_tuser[2:0];
  assign in_kind  = s_tuser[4:3];
  assign in_first = {s_tdata[63:0], s_tdata[127:64]};
  assign in_last  = {s_tdata[191:128], s_tdata[255:192]};
  assign in_plen  = s_tdata[263:256];
  assign in_v4    = s_tdata[264];

  logic [CW-1:0] staged_count, active_count, mk;
  logic          load_failed, act0_full;
  logic [IW-1:0] ri, rj, rank, mi, qi;
  addr_t         q_addr, cur_min, cur_max;
  range_t        item;
  logic          res_listed;
  logic [1:0]    res_status;

  // staging and active memories
  logic          stg_we, act_we;
  logic [IW-1:0] stg_waddr, stg_raddr, act_waddr, act_raddr;
  range_t        stg_wdata, act_wdata, stg_rd, act_rd;
  logic [RW-1:0] stg_rdata, act_rdata;

  assign stg_rd = range_t'(stg_rdata);
  assign act_rd = range_t'(act_rdata);

  ipral_ram #(.WIDTH(RW), .DEPTH(MAX_RANGES)) u_stg (
    .clk(clk), .we(stg_we), .waddr(stg_waddr), .wdata(stg_wdata),
    .raddr(stg_raddr), .rdata(stg_rdata)
  );

  ipral_ram #(.WIDTH(RW), .DEPTH(MAX_RANGES)) u_act (
    .clk(clk), .we(act_we), .waddr(act_waddr), .wdata(act_wdata),
    .raddr(act_raddr), .rdata(act_rdata)
  );

  // add item bounds
  logic [8:0] eff_len;
  logic [7:0] host_bits;
  addr_t      pmask;
  range_t     new_rng;
  logic       add_bad, add_full;

  always_comb begin
    eff_len   = {1'b0, in_plen} + (in_v4 ? 9'(IPV4_OFFSET) : 9'd0);
    host_bits = 8'(9'(FULL_LEN) - eff_len);
    pmask     = {ADDR_W{1'b1}} << host_bits;
    new_rng   = '{lo_bound: in_first, hi_bound: in_first};
    add_bad   = 1'b0;
    case (in_kind)
      KIND_SINGLE: new_rng = '{lo_bound: in_first, hi_bound: in_first};
      KIND_PREFIX: begin
        add_bad = eff_len > 9'(FULL_LEN);
        new_rng = '{lo_bound: in_first & pmask, hi_bound: in_first | ~pmask};
      end
      KIND_RANGE: begin
        add_bad = in_first > in_last;
        new_rng = '{lo_bound: in_first, hi_bound: in_last};
      end
      default: add_bad = 1'b1;
    endcase
    add_full = !add_bad && (staged_count >= CW'(MAX_RANGES));
  end

  logic accept;
  logic last_rj, last_ri, last_mi, last_qi, q_hit, rk_less, mg_join;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign last_rj  = CW'(rj) == staged_count - CW'(1);
  assign last_ri  = CW'(ri) == staged_count - CW'(1);
  assign last_mi  = CW'(mi) == staged_count - CW'(1);
  assign last_qi  = CW'(qi) == active_count - CW'(1);
  assign q_hit    = (act_rd.lo_bound <= q_addr) && (q_addr <= act_rd.hi_bound);
  assign rk_less  = (stg_rd.lo_bound < item.lo_bound) ||
                    ((stg_rd.lo_bound == item.lo_bound) && (rj < ri));
  assign mg_join  = (mk != '0) && (act_rd.lo_bound <= cur_max);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          state_next = S_RESP;
          if (in_func == FUNC_COMMIT && !load_failed && staged_count != '0) begin
            state_next = S_RK_ITEM;
          end
          if (in_func == FUNC_QUERY && active_count != '0) begin
            state_next = S_Q_SCAN;
          end
        end
      end
      S_Q_SCAN:   if (q_hit || last_qi) state_next = S_RESP;
      S_RK_ITEM:  state_next = S_RK_FIRST;
      S_RK_FIRST: state_next = S_RK_SCAN;
      S_RK_SCAN:  if (last_rj) state_next = S_RK_WR;
      S_RK_WR:    state_next = last_ri ? S_MG_RD : S_RK_ITEM;
      S_MG_RD:    state_next = S_MG_SCAN;
      S_MG_SCAN:  if (last_mi) state_next = S_MG_FIN;
      S_MG_FIN:   state_next = S_RESP;
      S_RESP:     if (!m_tvalid || m_tready) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // memory control
  always_comb begin
    stg_we    = 1'b0;
    stg_waddr = staged_count[IW-1:0];
    stg_wdata = new_rng;
    stg_raddr = '0;
    act_we    = 1'b0;
    act_waddr = '0;
    act_wdata = '{lo_bound: cur_min, hi_bound: cur_max};
    act_raddr = '0;
    case (state)
      S_IDLE: begin
        if (accept && in_func == FUNC_ADD && !add_bad && !add_full) stg_we = 1'b1;
        if (accept && in_func == FUNC_ALL) begin
          act_we    = 1'b1;
          act_wdata = '{lo_bound: '0, hi_bound: '1};
        end
      end
      S_Q_SCAN:   act_raddr = IW'(qi + IW'(1));
      S_RK_ITEM:  stg_raddr = ri;
      S_RK_FIRST: stg_raddr = '0;
      S_RK_SCAN:  stg_raddr = IW'(rj + IW'(1));
      S_RK_WR: begin
        act_we    = 1'b1;
        act_waddr = rank;
        act_wdata = item;
      end
      S_MG_RD:    act_raddr = mi;
      S_MG_SCAN: begin
        act_raddr = IW'(mi + IW'(1));
        act_we    = !mg_join && (mk != '0);
        act_waddr = IW'(mk - CW'(1));
      end
      S_MG_FIN: begin
        act_we    = 1'b1;
        act_waddr = IW'(mk - CW'(1));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      staged_count <= '0;
      load_failed  <= 1'b0;
      active_count <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_RESP && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (in_func)
              FUNC_BEGIN: begin
                staged_count <= '0;
                load_failed  <= 1'b0;
              end
              FUNC_ADD: begin
                if (add_bad || add_full) load_failed <= 1'b1;
                else staged_count <= staged_count + CW'(1);
              end
              FUNC_COMMIT: if (!load_failed && staged_count == '0) active_count <= '0;
              FUNC_ALL:    active_count <= CW'(1);
              FUNC_NONE:   active_count <= '0;
              default: ;
            endcase
          end
        end
        S_MG_FIN: active_count <= mk;
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (act_we && act_waddr == '0) begin
      act0_full <= (act_wdata.lo_bound == '0) && (act_wdata.hi_bound == '1);
    end
    case (state)
      S_IDLE: begin
        q_addr     <= in_first;
        qi         <= '0;
        ri         <= '0;
        mi         <= '0;
        mk         <= '0;
        res_listed <= 1'b0;
        res_status <= ST_OK;
        if (in_func == FUNC_ADD && add_bad) res_status <= ST_BAD;
        if (in_func == FUNC_ADD && add_full) res_status <= ST_FULL;
        if (in_func == FUNC_COMMIT && load_failed) res_status <= ST_REFUSED;
      end
      S_Q_SCAN: begin
        qi <= IW'(qi + IW'(1));
        if (q_hit) res_listed <= 1'b1;
      end
      S_RK_ITEM: rank <= '0;
      S_RK_FIRST: begin
        item <= stg_rd;
        rj   <= '0;
      end
      S_RK_SCAN: begin
        rj <= IW'(rj + IW'(1));
        if (rk_less) rank <= IW'(rank + IW'(1));
      end
      S_RK_WR: ri <= IW'(ri + IW'(1));
      S_MG_SCAN: begin
        mi <= IW'(mi + IW'(1));
        if (mg_join) begin
          if (act_rd.hi_bound > cur_max) cur_max <= act_rd.hi_bound;
        end else begin
          cur_min <= act_rd.lo_bound;
          cur_max <= act_rd.hi_bound;
          mk      <= mk + CW'(1);
        end
      end
      S_RESP: begin
        if (!m_tvalid || m_tready) begin
          m_tdata <= {4'd0, active_count == '0,
                      (active_count == CW'(1)) && act0_full,
                      7'(active_count), res_status, res_listed};
        end
      end
      default: ;
    endcase
  end

  a_staged_bound: assert property (@(posedge clk) disable iff (rst)
    staged_count <= CW'(MAX_RANGES))
    else $error("staged count above table size");

  a_active_bound: assert property (@(posedge clk) disable iff (rst)
    active_count <= CW'(MAX_RANGES))
    else $error("active count above table size");

  a_rank_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_RK_WR) |-> (CW'(rank) < staged_count))
    else $error("sort rank beyond staged items");

  a_merge_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_MG_FIN) |-> (mk != '0 && mk <= staged_count))
    else $error("merged count out of range");

  a_commit_gate: assert property (@(posedge clk) disable iff (rst)
    (state == S_RK_ITEM) |-> !load_failed)
    else $error("commit started on a failed load");

endmodule
